// ===== rtl/core/iq_dc_offset_canceller_top_defines.svh =====
`ifndef IQ_DC_OFFSET_CANCELLER_TOP_DEFINES_SVH
`define IQ_DC_OFFSET_CANCELLER_TOP_DEFINES_SVH

// Concurrent checks on the clk domain, disabled while arst_n is low.
`define IQDC_ASSERT(lbl, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error("iq_dc_offset_canceller check failed");

// The condition must never hold at a clock edge.
`define IQDC_NEVER(lbl, cond) `IQDC_ASSERT(lbl, !(cond))

`endif

// ===== rtl/core/iqdc_pkg.sv =====
`timescale 1ns / 1ps

package iqdc_pkg;

	localparam int SAMPLE_BITS = 32;
	localparam int IO_W = 32;
	localparam int SETTLE_W = 26;
	localparam int WCNT_W = 27;
	localparam int REM_W = WCNT_W + 1;
	localparam int SUM_W = 60;
	localparam int DIFF_W = IO_W + 1;
	localparam int DIV_STEPS = SUM_W;
	localparam int DIV_CNT_W = $clog2(DIV_STEPS);
	localparam logic [SETTLE_W-1:0] SETTLE_RESET = SETTLE_W'(48000);

	localparam logic signed [DIFF_W-1:0] SAT_HI =
		(DIFF_W'(1) <<< (SAMPLE_BITS - 1)) - DIFF_W'(1);
	localparam logic signed [DIFF_W-1:0] SAT_LO = -SAT_HI - DIFF_W'(1);

	typedef struct packed {
		logic key_down;
		logic signed [IO_W-1:0] sample_i;
		logic signed [IO_W-1:0] sample_q;
	} sample_t;

	typedef struct packed {
		logic signed [IO_W-1:0] out_i;
		logic signed [IO_W-1:0] out_q;
	} result_t;

	typedef struct packed {
		logic take;
		logic div_start;
		logic out_load;
	} cmd_t;

	typedef struct packed {
		logic close;
		logic div_done;
		logic out_free;
	} sts_t;

	function automatic logic signed [IO_W-1:0] sat(input logic signed [DIFF_W-1:0] d);
		logic signed [IO_W-1:0] r;
		if (d > SAT_HI) begin
			r = SAT_HI[IO_W-1:0];
		end else if (d < SAT_LO) begin
			r = SAT_LO[IO_W-1:0];
		end else begin
			r = d[IO_W-1:0];
		end
		return r;
	endfunction

endpackage

// ===== rtl/core/iqdc_div.sv =====
`timescale 1ns / 1ps

// Two signed-by-unsigned restoring dividers sharing one step counter.
module iqdc_div (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	input  logic signed [iqdc_pkg::SUM_W-1:0] num_i,
	input  logic signed [iqdc_pkg::SUM_W-1:0] num_q,
	input  logic [iqdc_pkg::WCNT_W-1:0] den,
	output logic done,
	output logic signed [iqdc_pkg::IO_W-1:0] quo_i,
	output logic signed [iqdc_pkg::IO_W-1:0] quo_q
);

	logic [iqdc_pkg::SUM_W-1:0] mag_q [2];
	logic [iqdc_pkg::REM_W-1:0] rem_q [2];
	logic neg_q [2];
	logic [iqdc_pkg::WCNT_W-1:0] den_q;
	logic [iqdc_pkg::DIV_CNT_W-1:0] cnt_q;
	logic busy_q;
	logic done_q;

	logic [iqdc_pkg::SUM_W-1:0] mag_n [2];
	logic [iqdc_pkg::REM_W-1:0] rem_n [2];
	logic [iqdc_pkg::SUM_W-1:0] abs_num [2];
	logic neg_num [2];
	logic signed [iqdc_pkg::IO_W-1:0] quo [2];

	always_comb begin
		neg_num[0] = num_i[iqdc_pkg::SUM_W-1];
		neg_num[1] = num_q[iqdc_pkg::SUM_W-1];
		abs_num[0] = neg_num[0] ? -num_i : num_i;
		abs_num[1] = neg_num[1] ? -num_q : num_q;
		for (int k = 0; k < 2; k++) begin
			logic [iqdc_pkg::REM_W-1:0] sh;
			logic ge;
			sh = {rem_q[k][iqdc_pkg::REM_W-2:0], mag_q[k][iqdc_pkg::SUM_W-1]};
			ge = sh >= {1'b0, den_q};
			rem_n[k] = ge ? sh - {1'b0, den_q} : sh;
			mag_n[k] = {mag_q[k][iqdc_pkg::SUM_W-2:0], ge};
			quo[k] = neg_q[k] ? -mag_q[k][iqdc_pkg::IO_W-1:0] : mag_q[k][iqdc_pkg::IO_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q <= '0;
			end else if (busy_q) begin
				if (cnt_q == iqdc_pkg::DIV_CNT_W'(iqdc_pkg::DIV_STEPS - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q + 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			den_q <= den;
			for (int k = 0; k < 2; k++) begin
				mag_q[k] <= abs_num[k];
				rem_q[k] <= '0;
				neg_q[k] <= neg_num[k];
			end
		end else if (busy_q) begin
			for (int k = 0; k < 2; k++) begin
				mag_q[k] <= mag_n[k];
				rem_q[k] <= rem_n[k];
			end
		end
	end

	assign done = done_q;
	assign quo_i = quo[0];
	assign quo_q = quo[1];

endmodule

// ===== rtl/core/iqdc_datapath.sv =====
`timescale 1ns / 1ps

module iqdc_datapath (
	input  logic clk,
	input  logic arst_n,
	input  iqdc_pkg::sample_t sample,
	input  logic settle_we,
	input  logic [iqdc_pkg::SETTLE_W-1:0] settle_wdata,
	input  iqdc_pkg::cmd_t cmd,
	output iqdc_pkg::sts_t sts,
	output logic result_valid,
	input  logic result_ready,
	output iqdc_pkg::result_t result
);

	logic [iqdc_pkg::SETTLE_W-1:0] settle_q;
	logic [iqdc_pkg::SETTLE_W-1:0] settle_cnt_q;
	logic [iqdc_pkg::WCNT_W-1:0] wcnt_q;
	logic signed [iqdc_pkg::SUM_W-1:0] sum_i_q;
	logic signed [iqdc_pkg::SUM_W-1:0] sum_q_q;
	logic signed [iqdc_pkg::IO_W-1:0] avg_i_q;
	logic signed [iqdc_pkg::IO_W-1:0] avg_q_q;
	logic signed [iqdc_pkg::IO_W-1:0] samp_i_s1;
	logic signed [iqdc_pkg::IO_W-1:0] samp_q_s1;
	iqdc_pkg::result_t result_q;
	logic out_valid_q;

	logic [iqdc_pkg::WCNT_W-1:0] wcnt_inc;
	logic signed [iqdc_pkg::SUM_W-1:0] sum_i_add;
	logic signed [iqdc_pkg::SUM_W-1:0] sum_q_add;
	logic settling;
	logic close;
	logic div_done;
	logic signed [iqdc_pkg::IO_W-1:0] quo_i;
	logic signed [iqdc_pkg::IO_W-1:0] quo_q;
	logic signed [iqdc_pkg::DIFF_W-1:0] diff_i;
	logic signed [iqdc_pkg::DIFF_W-1:0] diff_q;

	assign wcnt_inc = wcnt_q + 1'b1;
	assign sum_i_add = sum_i_q
		+ {{(iqdc_pkg::SUM_W - iqdc_pkg::IO_W){sample.sample_i[iqdc_pkg::IO_W-1]}},
			sample.sample_i};
	assign sum_q_add = sum_q_q
		+ {{(iqdc_pkg::SUM_W - iqdc_pkg::IO_W){sample.sample_q[iqdc_pkg::IO_W-1]}},
			sample.sample_q};
	assign settling = settle_cnt_q < settle_q;
	assign close = !sample.key_down && !settling
		&& ({1'b0, wcnt_inc} > {1'b0, settle_q, 1'b0});

	assign diff_i = {samp_i_s1[iqdc_pkg::IO_W-1], samp_i_s1}
		- {avg_i_q[iqdc_pkg::IO_W-1], avg_i_q};
	assign diff_q = {samp_q_s1[iqdc_pkg::IO_W-1], samp_q_s1}
		- {avg_q_q[iqdc_pkg::IO_W-1], avg_q_q};

	iqdc_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cmd.div_start),
		.num_i  (sum_i_add),
		.num_q  (sum_q_add),
		.den    (wcnt_inc),
		.done   (div_done),
		.quo_i  (quo_i),
		.quo_q  (quo_q)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			settle_q <= iqdc_pkg::SETTLE_RESET;
			settle_cnt_q <= '0;
			wcnt_q <= '0;
			sum_i_q <= '0;
			sum_q_q <= '0;
			avg_i_q <= '0;
			avg_q_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (settle_we) begin
				settle_q <= settle_wdata;
			end
			if (cmd.take) begin
				if (sample.key_down) begin
					settle_cnt_q <= '0;
					wcnt_q <= '0;
					sum_i_q <= '0;
					sum_q_q <= '0;
				end else if (settling) begin
					settle_cnt_q <= settle_cnt_q + 1'b1;
				end else if (close) begin
					wcnt_q <= '0;
					sum_i_q <= '0;
					sum_q_q <= '0;
				end else begin
					wcnt_q <= wcnt_inc;
					sum_i_q <= sum_i_add;
					sum_q_q <= sum_q_add;
				end
			end
			if (div_done) begin
				avg_i_q <= quo_i;
				avg_q_q <= quo_q;
			end
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (result_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.take) begin
			samp_i_s1 <= sample.sample_i;
			samp_q_s1 <= sample.sample_q;
		end
		if (cmd.out_load) begin
			result_q.out_i <= iqdc_pkg::sat(diff_i);
			result_q.out_q <= iqdc_pkg::sat(diff_q);
		end
	end

	assign sts.close = close;
	assign sts.div_done = div_done;
	assign sts.out_free = !out_valid_q || result_ready;
	assign result_valid = out_valid_q;
	assign result = result_q;

endmodule

// ===== rtl/core/iqdc_ctrl.sv =====
`timescale 1ns / 1ps

module iqdc_ctrl (
	input  logic clk,
	input  logic arst_n,
	input  logic sample_valid,
	output logic sample_ready,
	input  iqdc_pkg::sts_t sts,
	output iqdc_pkg::cmd_t cmd
);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_DIV  = 2'd1;
	localparam logic [1:0] ST_EMIT = 2'd2;

	logic [1:0] state_q;
	logic [1:0] state_n;

	always_comb begin
		state_n = state_q;
		cmd = '0;
		sample_ready = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				sample_ready = 1'b1;
				if (sample_valid) begin
					cmd.take = 1'b1;
					cmd.div_start = sts.close;
					state_n = sts.close ? ST_DIV : ST_EMIT;
				end
			end
			ST_DIV: begin
				if (sts.div_done) begin
					state_n = ST_EMIT;
				end
			end
			ST_EMIT: begin
				if (sts.out_free) begin
					cmd.out_load = 1'b1;
					state_n = ST_IDLE;
				end
			end
			default: begin
				state_n = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_n;
		end
	end

endmodule

// ===== rtl/core/iq_dc_offset_canceller_top.sv =====
`timescale 1ns / 1ps
// DC offset canceller for a complex I/Q receive stream.
// Input channel sample_valid/sample_ready/sample carries one I/Q sample and the
// transmit-key flag; output channel result_valid/result_ready/result carries
// the sample minus the running DC average, saturated to the sample range.
// settle_we/settle_wdata write the settle length; the user writes it only while
// the block is idle; the block itself does not enforce this. An ordinary sample
// goes from the idle state to the emit state, which loads the output register
// once it is free; no new sample is taken until the block is back in idle.
// A sample that closes an averaging window runs both quotients through a
// 60-step shift-subtract divider, one quotient bit per cycle; the controller
// waits in its divide state until the divider is done, then loads the output
// register from its emit state, and only then takes the next sample.
// Reset clears the counters, sums and averages and loads a settle length of
// 48000. A stalled receiver holds the result in the output register; one
// more sample is processed and then waits until the output register frees.
`include "iq_dc_offset_canceller_top_defines.svh"

module iq_dc_offset_canceller_top (
	input  logic clk,
	input  logic arst_n,
	input  logic settle_we,
	input  logic [iqdc_pkg::SETTLE_W-1:0] settle_wdata,
	input  logic sample_valid,
	output logic sample_ready,
	input  iqdc_pkg::sample_t sample,
	output logic result_valid,
	input  logic result_ready,
	output iqdc_pkg::result_t result
);

	iqdc_pkg::cmd_t cmd;
	iqdc_pkg::sts_t sts;

	iqdc_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.sample_valid (sample_valid),
		.sample_ready (sample_ready),
		.sts          (sts),
		.cmd          (cmd)
	);

	iqdc_datapath u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.sample       (sample),
		.settle_we    (settle_we),
		.settle_wdata (settle_wdata),
		.cmd          (cmd),
		.sts          (sts),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result)
	);

	`IQDC_NEVER(a_take_and_load, cmd.take && cmd.out_load)
	`IQDC_ASSERT(a_busy_after_take, cmd.take |=> !sample_ready)
	`IQDC_NEVER(a_done_while_idle, sts.div_done && sample_ready)

endmodule
